[hdl/cpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductivity probe averager package
// Shared constants, register indexes, width helpers and the status group
// that the serial ratio unit reports to the top level.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 1024;
   localparam int DEFAULT_ADC_BITS    = 10;

   // Width of the resistance registers and of the signed result.
   localparam int REG_W = 16;
   localparam int RES_W = 27;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVIDER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CABLE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWITCHING = 2'd2;

   localparam logic [REG_W-1:0] RESET_DIVIDER = 16'd1225;
   localparam logic [REG_W-1:0] RESET_CABLE   = 16'd250;

   // Request kinds carried in the request tuser bit.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } calc_stat_type;

   function automatic int count_width(int max_samples);
      return $clog2(max_samples + 1);
   endfunction

   function automatic int sum_width(int max_samples, int adc_bits);
      longint peak;
      peak = longint'(max_samples) * ((longint'(1) << adc_bits) - 1);
      return $clog2(peak + 1);
   endfunction

   function automatic int denom_width(int max_samples, int adc_bits);
      return $clog2((longint'(max_samples) << adc_bits) + 1);
   endfunction

   // The magnitude of the quotient stays below 2^(REG_W + adc_bits).
   function automatic int quot_width(int adc_bits);
      return REG_W + adc_bits;
   endfunction

endpackage

[hdl/conductivity_probe_averager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductivity probe averager
// Accumulates converter samples from a conductivity probe, mirroring every
// other one when the drive polarity alternates, and reports the averaged
// liquid resistance in tenths of an ohm on request.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Contents
// req     | in        | req_tvalid/req_tready  | sample or read request
// rsp     | out       | rsp_tvalid/rsp_tready  | resistance, count and flags
// csr     | in        | csr_we                 | divider, cable, switching
//
// Requests are accepted only while no read is in progress. During a read
// the serial multiply retires one resistor bit per cycle and the restoring
// divider one quotient bit per cycle. Synchronous reset restores the
// register defaults and clears the sum, the count, the phase and the dropped
// flag. The result sits in an output register, so samples keep flowing
// while a response is stalled and no read is in flight; a read whose result
// finds that register still full holds off all requests until it drains.
// ----------------------------------------------------------------------------
module conductivity_probe_averager #(
   parameter int MAX_SAMPLES = cpa_pkg::DEFAULT_MAX_SAMPLES,
   parameter int ADC_BITS    = cpa_pkg::DEFAULT_ADC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [cpa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cpa_pkg::REG_W-1:0]           csr_wdata,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, from bit 0: adc_sample, clear_after, zero fill.
   input  logic [((ADC_BITS + 1 + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: req_type.
   input  logic                                req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, from bit 0: resistance_tenths, samples_used, zero fill.
   output logic [((cpa_pkg::RES_W + cpa_pkg::count_width(MAX_SAMPLES) + 7) / 8) * 8 - 1:0]
                                               rsp_tdata,
   // tuser, from bit 0: result_valid, count_saturated.
   output logic [1:0]                          rsp_tuser
);

   localparam int RW    = cpa_pkg::REG_W;
   localparam int RES_W = cpa_pkg::RES_W;
   localparam int CW    = cpa_pkg::count_width(MAX_SAMPLES);
   localparam int SW    = cpa_pkg::sum_width(MAX_SAMPLES, ADC_BITS);
   localparam int DW    = cpa_pkg::denom_width(MAX_SAMPLES, ADC_BITS);
   localparam int QW    = cpa_pkg::quot_width(ADC_BITS);
   localparam int RSP_W = ((RES_W + CW + 7) / 8) * 8;
   localparam int EW    = (QW > RES_W) ? QW : RES_W;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CALC = 3'b010,
      T_HOLD = 3'b100
   } top_state_type;

   // Configuration registers.
   logic [RW-1:0]      div_ff, div_in;
   logic [RW-1:0]      cab_ff, cab_in;
   logic               sw_ff, sw_in;

   // Accumulators.
   logic [SW-1:0]      sum_ff, sum_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               phase_ff, phase_in;
   logic               drop_ff, drop_in;

   // Snapshot of the count and flag for the request in flight.
   logic [CW-1:0]      snap_count_ff, snap_count_in;
   logic               snap_drop_ff, snap_drop_in;

   top_state_type      state_ff, state_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic                  accept;
   logic                  is_read;
   logic                  start;
   logic                  full;
   logic [ADC_BITS-1:0]   sample;
   logic [DW-1:0]         denom;
   logic                  rsp_free;
   logic                  load_rsp;
   logic                  avg_valid;
   logic [EW-1:0]         q_ext;
   logic [EW-1:0]         q_signed;
   logic [RES_W-1:0]      result;

   cpa_pkg::calc_stat_type stat;
   logic                   negative;
   logic [QW-1:0]          quotient;

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_read    = (req_tuser == cpa_pkg::REQ_READ);
   assign start      = accept && is_read;
   assign full       = (count_ff >= CW'(MAX_SAMPLES));

   // Mirroring a sample around full scale is a bitwise inversion.
   assign sample = (sw_ff && phase_ff) ? ~req_tdata[ADC_BITS-1:0]
                                       : req_tdata[ADC_BITS-1:0];

   // Denominator full_scale * count - sum; never zero while the count is not.
   assign denom = (DW'(count_ff) << ADC_BITS) - DW'(sum_ff);

   // Configuration writes. Indexes past the list are ignored.
   always_comb begin
      div_in = div_ff;
      cab_in = cab_ff;
      sw_in  = sw_ff;
      if (csr_we) begin
         unique case (csr_index)
            cpa_pkg::CSR_DIVIDER:   div_in = csr_wdata;
            cpa_pkg::CSR_CABLE:     cab_in = csr_wdata;
            cpa_pkg::CSR_SWITCHING: sw_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Accumulation and snapshot. A read captures everything it needs at
   // acceptance, so the clear may take effect at once.
   always_comb begin
      sum_in        = sum_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      drop_in       = drop_ff;
      snap_count_in = snap_count_ff;
      snap_drop_in  = snap_drop_ff;
      if (accept) begin
         if (!is_read) begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               sum_in   = sum_ff + SW'(sample);
               count_in = count_ff + 1'b1;
            end
            // The probe was driven even when the sample is dropped.
            if (sw_ff) begin
               phase_in = !phase_ff;
            end
         end else begin
            snap_count_in = count_ff;
            snap_drop_in  = drop_ff;
            if (req_tdata[ADC_BITS]) begin
               sum_in   = '0;
               count_in = '0;
               drop_in  = 1'b0;
            end
         end
      end
   end

   cpa_ratio_div #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .ADC_BITS    (ADC_BITS)
   ) u_ratio (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sum_in     (sum_ff),
      .denom_in   (denom),
      .divider_in (div_ff),
      .cable_in   (cab_ff),
      .stat       (stat),
      .negative   (negative),
      .quotient   (quotient)
   );

   // Sign the quotient and force the empty-average case to zero.
   always_comb begin
      avg_valid = (snap_count_ff != '0);
      q_ext     = EW'(quotient);
      q_signed  = negative ? (~q_ext + 1'b1) : q_ext;
      result    = avg_valid ? q_signed[RES_W-1:0] : '0;
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign load_rsp = rsp_free && (((state_ff == T_CALC) && stat.done)
                                  || (state_ff == T_HOLD));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               state_in = T_CALC;
            end
         end
         T_CALC: begin
            if (stat.done) begin
               state_in = rsp_free ? T_IDLE : T_HOLD;
            end
         end
         T_HOLD: begin
            if (rsp_free) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({snap_count_ff, result});
         rsp_user_in  = {snap_drop_ff, avg_valid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= cpa_pkg::RESET_DIVIDER;
         cab_ff       <= cpa_pkg::RESET_CABLE;
         sw_ff        <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_ff       <= div_in;
         cab_ff       <= cab_in;
         sw_ff        <= sw_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         drop_ff      <= drop_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_count_ff <= snap_count_in;
      snap_drop_ff  <= snap_drop_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A read is only started while the ratio unit is free.
   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      start |-> !stat.busy)
      else $error("read started while the ratio unit was busy");

   // The unit finishes only for a read the top level is waiting on.
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == T_CALC))
      else $error("ratio unit finished outside of a calculation");

   // The count never passes its ceiling.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count above its ceiling");

   // A sample arriving at a full count marks the average as saturated.
   a_drop_on_full: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_read && full) |=> drop_ff)
      else $error("sample dropped without setting the saturation flag");

   // A clearing read leaves empty accumulators behind.
   a_clear_after_read: assert property (@(posedge clock) disable iff (reset)
      (start && req_tdata[ADC_BITS]) |=> (sum_ff == '0 && count_ff == '0 && !drop_ff))
      else $error("accumulators not cleared after a clearing read");

   // A valid average always reports a nonzero sample count.
   a_valid_has_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff[RES_W +: CW] != '0))
      else $error("valid result with an empty sample count");

endmodule

[hdl/cpa_ratio_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductivity probe averager ratio unit
// Radix-2 serial multiply of both products, then a restoring divide that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpa_ratio_div #(
   parameter int MAX_SAMPLES = cpa_pkg::DEFAULT_MAX_SAMPLES,
   parameter int ADC_BITS    = cpa_pkg::DEFAULT_ADC_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [cpa_pkg::sum_width(MAX_SAMPLES, ADC_BITS)-1:0]   sum_in,
   input  logic [cpa_pkg::denom_width(MAX_SAMPLES, ADC_BITS)-1:0] denom_in,
   input  logic [cpa_pkg::REG_W-1:0]                 divider_in,
   input  logic [cpa_pkg::REG_W-1:0]                 cable_in,
   output cpa_pkg::calc_stat_type                    stat,
   output logic                                      negative,
   output logic [cpa_pkg::quot_width(ADC_BITS)-1:0]  quotient
);

   localparam int RW  = cpa_pkg::REG_W;
   localparam int SW  = cpa_pkg::sum_width(MAX_SAMPLES, ADC_BITS);
   localparam int DW  = cpa_pkg::denom_width(MAX_SAMPLES, ADC_BITS);
   localparam int QW  = cpa_pkg::quot_width(ADC_BITS);
   localparam int PW  = RW + DW;
   localparam int SPW = $clog2(QW);

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_MUL  = 5'b00010,
      U_DIFF = 5'b00100,
      U_DIV  = 5'b01000,
      U_DONE = 5'b10000
   } unit_state_type;

   unit_state_type    state_ff, state_in;
   logic [SPW-1:0]    step_ff, step_in;
   logic [SW-1:0]     sum_op_ff, sum_op_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [RW-1:0]     rd_sh_ff, rd_sh_in;
   logic [RW-1:0]     rc_sh_ff, rc_sh_in;
   logic [PW-1:0]     num_acc_ff, num_acc_in;
   logic [PW-1:0]     off_acc_ff, off_acc_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic              neg_ff, neg_in;

   logic [PW:0]       diff_pos;
   logic [PW-1:0]     mag;
   logic [DW+1:0]     trial;
   logic              fits;

   always_comb begin
      diff_pos = {1'b0, num_acc_ff} - {1'b0, off_acc_ff};
      mag      = diff_pos[PW] ? (off_acc_ff - num_acc_ff) : diff_pos[PW-1:0];
      trial    = {1'b0, rem_ff, quo_ff[QW-1]} - {2'b00, den_ff};
      fits     = !trial[DW+1];
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      sum_op_in  = sum_op_ff;
      den_in     = den_ff;
      rd_sh_in   = rd_sh_ff;
      rc_sh_in   = rc_sh_ff;
      num_acc_in = num_acc_ff;
      off_acc_in = off_acc_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               sum_op_in  = sum_in;
               den_in     = denom_in;
               rd_sh_in   = divider_in;
               rc_sh_in   = cable_in;
               num_acc_in = '0;
               off_acc_in = '0;
               step_in    = SPW'(RW - 1);
               state_in   = U_MUL;
            end
         end
         U_MUL: begin
            // Multiplier bits are taken from the top down, one per cycle.
            num_acc_in = {num_acc_ff[PW-2:0], 1'b0}
                         + (rd_sh_ff[RW-1] ? PW'(sum_op_ff) : '0);
            off_acc_in = {off_acc_ff[PW-2:0], 1'b0}
                         + (rc_sh_ff[RW-1] ? PW'(den_ff) : '0);
            rd_sh_in   = {rd_sh_ff[RW-2:0], 1'b0};
            rc_sh_in   = {rc_sh_ff[RW-2:0], 1'b0};
            step_in    = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = U_DIFF;
            end
         end
         U_DIFF: begin
            // The top bits of the magnitude are already below the divisor.
            neg_in   = diff_pos[PW];
            rem_in   = DW'(mag[PW-1:QW]);
            quo_in   = mag[QW-1:0];
            step_in  = SPW'(QW - 1);
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in  = fits ? trial[DW-1:0] : {rem_ff[DW-2:0], quo_ff[QW-1]};
            quo_in  = {quo_ff[QW-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = U_DONE;
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      sum_op_ff  <= sum_op_in;
      den_ff     <= den_in;
      rd_sh_ff   <= rd_sh_in;
      rc_sh_ff   <= rc_sh_in;
      num_acc_ff <= num_acc_in;
      off_acc_ff <= off_acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
   end

   assign stat.busy = (state_ff != U_IDLE);
   assign stat.done = (state_ff == U_DONE);
   assign negative  = neg_ff;
   assign quotient  = quo_ff;

endmodule
